// ===== hw/rtl/marker_seek_planner_core_macros.svh =====
// Assertion helpers shared by the planner RTL. They assume the house clock
// and reset names clk and rst.
`ifndef MARKER_SEEK_PLANNER_CORE_MACROS_SVH
`define MARKER_SEEK_PLANNER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MSP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("planner check failed");

// Next-cycle implication, checked outside reset.
`define MSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("planner check failed");

`endif

// ===== hw/rtl/msp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package msp_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_SEARCH = 3'd1,
    MODE_START  = 3'd2,
    MODE_TURN   = 3'd3,
    MODE_DRIVE  = 3'd4,
    MODE_TARGET = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    REG_LINEAR_GAIN     = 3'd0,
    REG_ANGULAR_GAIN    = 3'd1,
    REG_WANTED_DISTANCE = 3'd2,
    REG_TARGET_ID       = 3'd3,
    REG_START_ID        = 3'd4,
    REG_LOST_TIMEOUT    = 3'd5,
    REG_TURN_DURATION   = 3'd6
  } reg_idx_t;

  localparam int ADDR_W = 5;

  localparam logic [31:0] LIN_MAX = 32'd80000;
  localparam logic [31:0] LIN_MIN = 32'd30000;
  localparam logic [31:0] ROT_MAX = 32'd628318;
  localparam logic [31:0] ROT_MIN = 32'd188496;
  localparam logic [15:0] ANG_THRESH = 16'd8;
  localparam logic [15:0] LIN_THRESH = 16'd10;

  typedef struct packed {
    logic              func;
    logic [9:0]        tag_id;
    logic signed [15:0] marker_x;
    logic [15:0]       marker_z;
  } tick_t;

  typedef struct packed {
    logic signed [17:0] fwd_speed;
    logic signed [20:0] yaw_rate;
    logic [2:0]         planner_mode;
    logic               marker_seen;
  } cmd_t;

  typedef struct packed {
    logic [23:0] linear_gain;
    logic [23:0] angular_gain;
    logic [15:0] wanted_distance;
    logic [9:0]  target_id;
    logic [9:0]  start_id;
    logic [15:0] lost_timeout;
    logic [19:0] turn_duration;
  } cfg_t;

  // All the speed stage needs of a tick: the mode that acted, rest updated.
  typedef struct packed {
    mode_t       mode;
    logic        seen;
    logic [15:0] abs_x;
    logic        x_pos;
    logic [15:0] abs_de;
    logic        de_neg;
    logic        amove;
    logic        lmove;
  } snap_t;

endpackage

`default_nettype wire

// ===== hw/rtl/msp_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module msp_regs (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [msp_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]               pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output msp_pkg::cfg_t                  cfg
);
  import msp_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.linear_gain     <= 24'd128000;
      cfg.angular_gain    <= 24'd1280000;
      cfg.wanted_distance <= 16'd250;
      cfg.target_id       <= 10'd42;
      cfg.start_id        <= 10'd0;
      cfg.lost_timeout    <= 16'd500;
      cfg.turn_duration   <= 20'd10000;
    end else if (wr_en) begin
      unique case (idx)
        REG_LINEAR_GAIN:     cfg.linear_gain     <= pwdata[23:0];
        REG_ANGULAR_GAIN:    cfg.angular_gain    <= pwdata[23:0];
        REG_WANTED_DISTANCE: cfg.wanted_distance <= pwdata[15:0];
        REG_TARGET_ID:       cfg.target_id       <= pwdata[9:0];
        REG_START_ID:        cfg.start_id        <= pwdata[9:0];
        REG_LOST_TIMEOUT:    cfg.lost_timeout    <= pwdata[15:0];
        REG_TURN_DURATION:   cfg.turn_duration   <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LINEAR_GAIN:     prdata = {8'd0, cfg.linear_gain};
      REG_ANGULAR_GAIN:    prdata = {8'd0, cfg.angular_gain};
      REG_WANTED_DISTANCE: prdata = {16'd0, cfg.wanted_distance};
      REG_TARGET_ID:       prdata = {22'd0, cfg.target_id};
      REG_START_ID:        prdata = {22'd0, cfg.start_id};
      REG_LOST_TIMEOUT:    prdata = {16'd0, cfg.lost_timeout};
      REG_TURN_DURATION:   prdata = {12'd0, cfg.turn_duration};
      default:             prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/msp_speed.sv =====
`timescale 1ns / 1ps
`default_nettype none

module msp_speed (
  input  wire msp_pkg::snap_t snap,
  input  wire logic [23:0] linear_gain,
  input  wire logic [23:0] angular_gain,
  output msp_pkg::cmd_t  cmd
);
  import msp_pkg::*;

  logic [39:0] ang_prod;
  logic [39:0] lin_prod;
  logic [31:0] ang_raw;
  logic [31:0] lin_raw;
  logic [31:0] ang_mag;
  logic [31:0] lin_mag;
  logic signed [20:0] ang_signed;
  logic signed [17:0] lin_signed;

  assign ang_prod = {24'd0, snap.abs_x} * {16'd0, angular_gain};
  assign lin_prod = {24'd0, snap.abs_de} * {16'd0, linear_gain};
  assign ang_raw  = ang_prod[39:8];
  assign lin_raw  = lin_prod[39:8];

  // A zero product still lands on the minimum speed.
  always_comb begin
    if (ang_raw >= ROT_MAX)      ang_mag = ROT_MAX;
    else if (ang_raw <= ROT_MIN) ang_mag = ROT_MIN;
    else                         ang_mag = ang_raw;
    if (lin_raw >= LIN_MAX)      lin_mag = LIN_MAX;
    else if (lin_raw <= LIN_MIN) lin_mag = LIN_MIN;
    else                         lin_mag = lin_raw;
  end

  assign ang_signed = snap.x_pos  ? -$signed(ang_mag[20:0]) : $signed(ang_mag[20:0]);
  assign lin_signed = snap.de_neg ? -$signed(lin_mag[17:0]) : $signed(lin_mag[17:0]);

  always_comb begin
    cmd.fwd_speed    = 18'sd0;
    cmd.yaw_rate     = 21'sd0;
    cmd.planner_mode = snap.mode;
    cmd.marker_seen  = snap.seen;
    case (snap.mode)
      MODE_START, MODE_TURN: begin
        cmd.yaw_rate = $signed(ROT_MAX[20:0]);
      end
      MODE_DRIVE: begin
        if (snap.amove) cmd.yaw_rate  = ang_signed;
        if (snap.lmove) cmd.fwd_speed = lin_signed;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/marker_seek_planner_core.sv =====
// Marker seek planner. One word on the tick channel is one 1 ms planner tick,
// optionally carrying a marker report (func high). Every tick yields exactly one
// word on the cmd channel: linear and angular speed, the planner mode that acted
// and whether a marker is currently tracked.
//
// The planner state is updated in the cycle a tick is accepted, together with a
// snapshot for the speed stage; the speed multiplies and clamps run from that
// snapshot into the cmd register once the cmd side can advance. One tick is
// taken per cycle while tick_stall is low; the single state update completes in
// the accept cycle.
//
// When cmd_stall is high the cmd word holds; one further tick can still be
// taken into the middle stage before tick_stall rises.
//
// Reset (rst, synchronous) empties both stages, returns the registers to their
// documented values and puts the planner in idle with no marker seen.
// Registers sit on the APB port at byte address 4*index and should be written
// only while no tick is in flight.
`timescale 1ns / 1ps
`default_nettype none

module marker_seek_planner_core (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      tick_valid,
  output logic                           tick_stall,
  input  wire msp_pkg::tick_t            tick,
  output logic                           cmd_valid,
  input  wire logic                      cmd_stall,
  output msp_pkg::cmd_t                  cmd,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [msp_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]               pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import msp_pkg::*;

  `include "marker_seek_planner_core_macros.svh"

  cfg_t cfg;

  // Planner state
  mode_t              mode;
  mode_t              mode_next;
  logic               seen_valid;
  logic [9:0]         seen_id;
  logic signed [16:0] last_x;
  logic signed [17:0] distance_error;
  logic [15:0]        since_seen;
  logic [19:0]        turn_elapsed;
  logic               turn_done;

  logic               seen_valid_next;
  logic [9:0]         seen_id_next;
  logic signed [16:0] last_x_next;
  logic signed [17:0] distance_error_next;
  logic [15:0]        since_seen_next;
  logic [19:0]        turn_elapsed_next;
  logic [19:0]        turn_inc;
  logic               turn_done_next;

  logic        tgt;
  logic [15:0] abs_x;
  logic [15:0] abs_de;
  logic        x_small;
  logic        de_small;
  logic        amove;
  logic        lmove;

  // Pipeline
  logic  s1_valid;
  snap_t snap;
  snap_t snap_next;
  logic  advance;
  logic  tick_acc;
  cmd_t  cmd_next;

  msp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign advance    = !cmd_valid || !cmd_stall;
  assign tick_stall = s1_valid && !advance;
  assign tick_acc   = tick_valid && !tick_stall;

  // Report or timer update, ahead of the planner decision.
  always_comb begin
    seen_valid_next     = seen_valid;
    seen_id_next        = seen_id;
    last_x_next         = last_x;
    distance_error_next = distance_error;
    since_seen_next     = since_seen;
    if (tick.func) begin
      seen_valid_next     = 1'b1;
      seen_id_next        = tick.tag_id;
      since_seen_next     = 16'd0;
      last_x_next         = 17'(tick.marker_x);
      distance_error_next = $signed({2'b00, tick.marker_z})
                          - $signed({2'b00, cfg.wanted_distance});
    end else begin
      if (since_seen != 16'hFFFF) since_seen_next = since_seen + 16'd1;
      if (since_seen_next >= cfg.lost_timeout) seen_valid_next = 1'b0;
    end
  end

  assign tgt      = seen_valid_next && (seen_id_next == cfg.target_id);
  assign abs_x    = last_x_next[16] ? 16'(-last_x_next) : 16'(last_x_next);
  assign abs_de   = distance_error_next[17] ? 16'(-distance_error_next)
                                            : 16'(distance_error_next);
  assign x_small  = abs_x <= ANG_THRESH;
  assign de_small = abs_de <= LIN_THRESH;
  assign turn_inc = (turn_elapsed != 20'hFFFFF) ? turn_elapsed + 20'd1 : turn_elapsed;

  // Next state
  always_comb begin
    mode_next = mode;
    unique case (mode)
      MODE_SEARCH: mode_next = tgt ? MODE_DRIVE : MODE_START;
      MODE_START:  mode_next = MODE_TURN;
      MODE_TURN: begin
        if (tgt)            mode_next = MODE_DRIVE;
        else if (turn_done) mode_next = MODE_IDLE;
      end
      MODE_DRIVE: begin
        if (!tgt)                      mode_next = MODE_SEARCH;
        else if (x_small && de_small)  mode_next = MODE_TARGET;
      end
      MODE_TARGET: begin
        if (!tgt || !x_small || !de_small) mode_next = MODE_SEARCH;
      end
      default: begin
        if (seen_valid_next && (seen_id_next == cfg.start_id)) mode_next = MODE_SEARCH;
      end
    endcase
  end

  // State outputs: turn timer and drive gating
  always_comb begin
    turn_elapsed_next = turn_elapsed;
    turn_done_next    = turn_done;
    amove             = 1'b1;
    lmove             = 1'b1;
    unique case (mode)
      MODE_SEARCH: turn_done_next = 1'b0;
      MODE_START:  turn_elapsed_next = 20'd0;
      MODE_TURN: begin
        turn_elapsed_next = turn_inc;
        // The cleared flag can be set again by the timer in the same tick.
        if (tgt) turn_done_next = 1'b0;
        if (turn_inc >= cfg.turn_duration) turn_done_next = 1'b1;
      end
      MODE_DRIVE: begin
        if (tgt) begin
          amove = !x_small;
          lmove = !de_small;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    snap_next.mode   = mode;
    snap_next.seen   = seen_valid_next;
    snap_next.abs_x  = abs_x;
    snap_next.x_pos  = !last_x_next[16] && (last_x_next != 17'sd0);
    snap_next.abs_de = abs_de;
    snap_next.de_neg = distance_error_next[17];
    snap_next.amove  = amove;
    snap_next.lmove  = lmove;
  end

  msp_speed u_speed (
    .snap         (snap),
    .linear_gain  (cfg.linear_gain),
    .angular_gain (cfg.angular_gain),
    .cmd          (cmd_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_IDLE;
      seen_valid     <= 1'b0;
      seen_id        <= 10'd0;
      last_x         <= 17'sd1000;
      distance_error <= 18'sd1000;
      since_seen     <= 16'd0;
      turn_elapsed   <= 20'd0;
      turn_done      <= 1'b0;
      s1_valid       <= 1'b0;
      cmd_valid      <= 1'b0;
    end else begin
      if (tick_acc) begin
        mode           <= mode_next;
        seen_valid     <= seen_valid_next;
        seen_id        <= seen_id_next;
        last_x         <= last_x_next;
        distance_error <= distance_error_next;
        since_seen     <= since_seen_next;
        turn_elapsed   <= turn_elapsed_next;
        turn_done      <= turn_done_next;
      end
      s1_valid <= tick_acc || (s1_valid && !advance);
      if (advance) cmd_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_acc) snap <= snap_next;
    if (advance && s1_valid) cmd <= cmd_next;
  end

  `MSP_ASSERT_NOW(a_idle_still,
    cmd_valid && (cmd.planner_mode == MODE_IDLE || cmd.planner_mode == MODE_SEARCH),
    cmd.fwd_speed == 18'sd0 && cmd.yaw_rate == 21'sd0)
  `MSP_ASSERT_NEXT(a_start_to_turn,
    tick_acc && mode == MODE_START,
    mode == MODE_TURN && turn_elapsed == 20'd0)
  `MSP_ASSERT_NEXT(a_report_seen,
    tick_acc && tick.func,
    seen_valid && since_seen == 16'd0 && snap.seen)
  `MSP_ASSERT_NOW(a_lin_bound,
    cmd_valid,
    cmd.fwd_speed <= 18'sd80000 && cmd.fwd_speed >= -18'sd80000)

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import msp_pkg::*;

  localparam int TICK_W = $bits(tick_t);
  localparam int CYCLE_LIMIT = 400000;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_HOLD} stall_kind_t;

  // Tracks the planner from the accepted ticks and holds the cmd words it owes.
  class planner_scoreboard;
    cfg_t cfg;
    mode_t mode;
    bit seen_valid;
    logic [9:0] seen_id;
    int last_x;
    int dist_err;
    int unsigned since_seen;
    int unsigned turn_elapsed;
    bit turn_done;
    cmd_t owed_cmds[$];
    int unsigned ticks;
    int unsigned checked;
    int unsigned mismatches;
    bit [5:0] modes_hit;

    function new();
      cfg.linear_gain = 24'd128000;
      cfg.angular_gain = 24'd1280000;
      cfg.wanted_distance = 16'd250;
      cfg.target_id = 10'd42;
      cfg.start_id = 10'd0;
      cfg.lost_timeout = 16'd500;
      cfg.turn_duration = 20'd10000;
      mode = MODE_IDLE;
      seen_valid = 1'b0;
      seen_id = '0;
      last_x = 1000;
      dist_err = 1000;
      since_seen = 0;
      turn_elapsed = 0;
      turn_done = 1'b0;
    endfunction

    function logic [31:0] write_reg(reg_idx_t idx, logic [31:0] v);
      logic [31:0] kept;
      case (idx)
        REG_LINEAR_GAIN, REG_ANGULAR_GAIN: kept = v & 32'h00FF_FFFF;
        REG_WANTED_DISTANCE, REG_LOST_TIMEOUT: kept = v & 32'h0000_FFFF;
        REG_TARGET_ID, REG_START_ID: kept = v & 32'h0000_03FF;
        default: kept = v & 32'h000F_FFFF;
      endcase
      case (idx)
        REG_LINEAR_GAIN: cfg.linear_gain = kept[23:0];
        REG_ANGULAR_GAIN: cfg.angular_gain = kept[23:0];
        REG_WANTED_DISTANCE: cfg.wanted_distance = kept[15:0];
        REG_TARGET_ID: cfg.target_id = kept[9:0];
        REG_START_ID: cfg.start_id = kept[9:0];
        REG_LOST_TIMEOUT: cfg.lost_timeout = kept[15:0];
        default: cfg.turn_duration = kept[19:0];
      endcase
      return kept;
    endfunction

    function int unsigned magnitude(int v);
      return (v < 0) ? -v : v;
    endfunction

    // Proportional term with the Q16.8 fraction dropped, held between lo and hi.
    function longint clamp_speed(int unsigned mag, logic [23:0] gain, longint lo, longint hi);
      longint unsigned prod;
      prod = (64'(mag) * 64'(gain)) >> 8;
      if (longint'(prod) >= hi) return hi;
      if (longint'(prod) <= lo) return lo;
      return longint'(prod);
    endfunction

    function cmd_t step_planner(tick_t t);
      mode_t cur;
      mode_t nxt;
      longint lin;
      longint ang;
      bit amove;
      bit lmove;
      bit on_target;
      cmd_t c;
      cur = mode;
      nxt = mode;
      lin = 0;
      ang = 0;
      amove = 1'b1;
      lmove = 1'b1;
      if (t.func) begin
        seen_valid = 1'b1;
        seen_id = t.tag_id;
        since_seen = 0;
        last_x = int'($signed(t.marker_x));
        dist_err = int'({16'h0, t.marker_z}) - int'({16'h0, cfg.wanted_distance});
      end else begin
        if (since_seen < 65535) since_seen++;
        if (since_seen >= cfg.lost_timeout) seen_valid = 1'b0;
      end
      on_target = seen_valid && (seen_id == cfg.target_id);
      case (cur)
        MODE_SEARCH: begin
          nxt = on_target ? MODE_DRIVE : MODE_START;
          turn_done = 1'b0;
        end
        MODE_START: begin
          nxt = MODE_TURN;
          turn_elapsed = 0;
          ang = ROT_MAX;
        end
        MODE_TURN: begin
          // The done flag from earlier ticks decides; this tick's count comes after.
          if (on_target) begin
            nxt = MODE_DRIVE;
            turn_done = 1'b0;
          end else if (turn_done) begin
            nxt = MODE_IDLE;
          end
          if (turn_elapsed < 20'hFFFFF) turn_elapsed++;
          if (turn_elapsed >= cfg.turn_duration) turn_done = 1'b1;
          ang = ROT_MAX;
        end
        MODE_DRIVE: begin
          // With the wrong marker the speeds still come out, without the dead band.
          if (!on_target) begin
            nxt = MODE_SEARCH;
          end else begin
            amove = magnitude(last_x) > ANG_THRESH;
            lmove = magnitude(dist_err) > LIN_THRESH;
            if (!amove && !lmove) nxt = MODE_TARGET;
          end
          ang = clamp_speed(magnitude(last_x), cfg.angular_gain, ROT_MIN, ROT_MAX);
          if (last_x > 0) ang = -ang;
          if (!amove) ang = 0;
          lin = clamp_speed(magnitude(dist_err), cfg.linear_gain, LIN_MIN, LIN_MAX);
          if (dist_err < 0) lin = -lin;
          if (!lmove) lin = 0;
        end
        MODE_TARGET: begin
          if (!on_target || magnitude(last_x) > ANG_THRESH ||
              magnitude(dist_err) > LIN_THRESH) nxt = MODE_SEARCH;
        end
        default: begin
          if (seen_valid && seen_id == cfg.start_id) nxt = MODE_SEARCH;
        end
      endcase
      modes_hit[cur] = 1'b1;
      mode = nxt;
      c.fwd_speed = 18'(lin);
      c.yaw_rate = 21'(ang);
      c.planner_mode = cur;
      c.marker_seen = seen_valid;
      return c;
    endfunction

    function void take_tick(tick_t t);
      owed_cmds.push_back(step_planner(t));
      ticks++;
    endfunction

    function bit count_mismatch();
      mismatches++;
      return mismatches <= 10;
    endfunction

    function void check_field(string what, logic signed [63:0] want, logic signed [63:0] got);
      if (got !== want) begin
        if (count_mismatch())
          $display("%0t word %0d: %s expected %0d, got %0d", $realtime, checked, what,
                   want, got);
      end
    endfunction

    function void check_cmd(cmd_t got);
      cmd_t want;
      if (owed_cmds.size() == 0) begin
        if (count_mismatch())
          $display("%0t cmd word arrived with nothing pending: %p", $realtime, got);
        return;
      end
      want = owed_cmds.pop_front();
      checked++;
      check_field("fwd_speed", want.fwd_speed, got.fwd_speed);
      check_field("yaw_rate", want.yaw_rate, got.yaw_rate);
      check_field("planner_mode", want.planner_mode, got.planner_mode);
      check_field("marker_seen", want.marker_seen, got.marker_seen);
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic tick_valid = 1'b0;
  logic tick_stall;
  tick_t tick = '0;
  logic cmd_valid;
  logic cmd_stall = 1'b0;
  cmd_t cmd;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  planner_scoreboard sb = new();
  int unsigned cycle_count;
  int unsigned reg_writes;
  int burst_left;
  bit gappy;
  int stall_left;
  stall_kind_t stall_kind = STALL_NONE;

  marker_seek_planner_core dut (
    .clk(clk),
    .rst(rst),
    .tick_valid(tick_valid),
    .tick_stall(tick_stall),
    .tick(tick),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && cmd_valid && !cmd_stall) sb.check_cmd(cmd);
  end

  // The cmd side stalls in segments of varying density, including none at all.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_kind = stall_kind_t'($urandom_range(0, 3));
      stall_left = $urandom_range(8, 60);
    end else begin
      stall_left--;
    end
    case (stall_kind)
      STALL_NONE: cmd_stall <= 1'b0;
      STALL_LIGHT: cmd_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: cmd_stall <= ($urandom_range(0, 3) != 0);
      default: cmd_stall <= 1'b1;
    endcase
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Planner run did not finish within %0d cycles", CYCLE_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  function automatic tick_t plain();
    tick_t t;
    t = TICK_W'({$urandom, $urandom});
    t.func = 1'b0;
    return t;
  endfunction

  function automatic tick_t report(int id, int x, int z);
    tick_t t;
    t.func = 1'b1;
    t.tag_id = 10'(id);
    t.marker_x = 16'(x);
    t.marker_z = 16'(z);
    return t;
  endfunction

  function automatic logic [23:0] some_gain();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      2: return 24'($urandom);
      default: return 24'($urandom_range(20000, 300000));
    endcase
  endfunction

  // Entered and left on a falling edge.
  task automatic send(input tick_t t);
    if (burst_left == 0) begin
      if (gappy) begin
        tick_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    tick <= t;
    tick_valid <= 1'b1;
    do @(posedge clk); while (tick_stall);
    sb.take_tick(t);
    @(negedge clk);
  endtask

  task automatic drain();
    tick_valid <= 1'b0;
    while (sb.owed_cmds.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Writes one register, then reads it back through the same port.
  task automatic apb_write_read(input reg_idx_t idx, input logic [31:0] v);
    logic [31:0] kept;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    kept = sb.write_reg(idx, v);
    reg_writes++;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.check_field("register readback", kept, prdata);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Unused upper data bits carry junk; the registers must ignore them.
  task automatic program_regs(input cfg_t c);
    apb_write_read(REG_LINEAR_GAIN, {8'($urandom), c.linear_gain});
    apb_write_read(REG_ANGULAR_GAIN, {8'($urandom), c.angular_gain});
    apb_write_read(REG_WANTED_DISTANCE, {16'($urandom), c.wanted_distance});
    apb_write_read(REG_TARGET_ID, {22'($urandom), c.target_id});
    apb_write_read(REG_START_ID, {22'($urandom), c.start_id});
    apb_write_read(REG_LOST_TIMEOUT, {16'($urandom), c.lost_timeout});
    apb_write_read(REG_TURN_DURATION, {12'($urandom), c.turn_duration});
  endtask

  // Most often reports of the tracked marker close to the dead band, so the planner
  // keeps cycling through drive and target; the rest is start reports, stray
  // markers and runs of bare ticks that let the marker time out.
  task automatic random_ticks(input int n);
    int k;
    int run;
    int unsigned r;
    tick_t t;
    k = 0;
    while (k < n) begin
      t = TICK_W'({$urandom, $urandom});
      r = $urandom_range(0, 99);
      if (r < 12) begin
        t.func = 1'b0;
      end else if (r < 22) begin
        t.func = 1'b1;
        t.tag_id = sb.cfg.start_id;
      end else if (r < 62) begin
        t.func = 1'b1;
        t.tag_id = sb.cfg.target_id;
        if ($urandom_range(0, 3) != 0) t.marker_x = 16'($urandom_range(0, 26)) - 16'd13;
        if ($urandom_range(0, 3) != 0)
          t.marker_z = sb.cfg.wanted_distance + 16'($urandom_range(0, 26)) - 16'd13;
      end else if (r < 80) begin
        t.func = 1'b1;
      end else begin
        run = $urandom_range(1, 30);
        repeat (run) send(plain());
        k += run;
        continue;
      end
      send(t);
      k++;
    end
  endtask

  initial begin
    cfg_t c;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    burst_left = 0;
    gappy = 1'b0;

    // Short timer settings so one pass walks idle, search, the timed turn and back.
    c = sb.cfg;
    c.turn_duration = 20'd2;
    c.lost_timeout = 16'd3;
    program_regs(c);
    send(plain());
    send(report(0, -32768, 0));
    repeat (6) send(plain());
    send(report(0, 5, 250));
    send(report(42, 32767, 65535));
    send(report(42, 9, 261));
    send(report(42, -8, 240));
    send(report(42, 8, 260));
    send(report(42, -9, 250));
    send(report(42, 0, 250));
    send(report(7, 100, 1000));
    send(report(1023, -1, 250));
    send(plain());
    drain();

    // Zero linear gain, full angular gain and a timeout that drops the marker
    // on every bare tick.
    c.linear_gain = '0;
    c.angular_gain = '1;
    c.wanted_distance = '1;
    c.target_id = 10'd1023;
    c.start_id = 10'd1023;
    c.lost_timeout = '0;
    c.turn_duration = '1;
    program_regs(c);
    send(report(1023, -32768, 0));
    send(report(1023, -32768, 0));
    send(plain());
    send(report(1023, 32767, 65535));
    send(report(1023, 1, 65535));
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          c.linear_gain = '1;
          c.angular_gain = '1;
          c.wanted_distance = '1;
          c.target_id = '1;
          c.start_id = '1;
          c.lost_timeout = '1;
          c.turn_duration = '1;
        end
        1: begin
          c = '0;
        end
        2: begin
          c.linear_gain = 24'd128000;
          c.angular_gain = 24'd1280000;
          c.wanted_distance = 16'd250;
          c.target_id = 10'd42;
          c.start_id = 10'd0;
          c.lost_timeout = 16'd6;
          c.turn_duration = 20'd12;
        end
        default: begin
          c.linear_gain = some_gain();
          c.angular_gain = some_gain();
          c.wanted_distance = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 1) * 65535)
                                                         : 16'($urandom);
          c.target_id = 10'($urandom);
          c.start_id = ($urandom_range(0, 2) == 0) ? c.target_id : 10'($urandom);
          c.lost_timeout = 16'($urandom_range(1, 12));
          c.turn_duration = 20'($urandom_range(0, 20));
        end
      endcase
      program_regs(c);
      gappy = ($urandom_range(0, 2) != 0);
      random_ticks(60);
      drain();
    end

    $display("Checked %0d cmd words against %0d predicted ticks; %0d register writes read back.",
             sb.checked, sb.ticks, reg_writes);
    $display("Planner modes visited, idle in the low bit: %b", sb.modes_hit);
    if (sb.owed_cmds.size() != 0)
      $display("%0d cmd words were never delivered", sb.owed_cmds.size());
    if (sb.mismatches == 0 && sb.owed_cmds.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/msp_pkg.sv
hw/rtl/msp_regs.sv
hw/rtl/msp_speed.sv
hw/rtl/marker_seek_planner_core.sv
bench/testbench.sv
